// ===== hdl/lfpp_pkg.sv =====
package lfpp_pkg;

  // Kind of a result item
  typedef enum logic [1:0] {
    KIND_POINT     = 2'd0,
    KIND_FRAME_END = 2'd1,
    KIND_BAD_MAGIC = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] point_x;
    logic [31:0] point_z;
  } res_t;

  localparam int PointsPerPackageDefault = 96;
  localparam int QueueDepth = 2;

  // Field lengths and byte positions, in bytes
  localparam logic [6:0] MagicLen    = 7'd10;
  localparam logic [6:0] HdrSkipLen  = 7'd78;
  localparam logic [6:0] FrameHdrLen = 7'd24;
  localparam logic [6:0] OffsetFirst = 7'd8;
  localparam logic [6:0] OffsetEnd   = 7'd16;
  localparam logic [6:0] PkgHdrLen   = 7'd19;
  localparam logic [6:0] TypeByte    = 7'd10;
  localparam logic [6:0] PointLen    = 7'd14;
  localparam logic [6:0] XEnd        = 7'd4;
  localparam logic [6:0] ZFirst      = 7'd8;
  localparam logic [6:0] ZLast       = 7'd11;
  localparam logic [6:0] BodySkipLen = 7'd24;
  localparam logic [7:0] PointType   = 8'd2;

  function automatic logic [7:0] magic_byte(input logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd0:    v = 8'h6C;
      4'd1:    v = 8'h69;
      4'd2:    v = 8'h76;
      4'd3:    v = 8'h6F;
      4'd4:    v = 8'h78;
      4'd5:    v = 8'h5F;
      4'd6:    v = 8'h74;
      4'd7:    v = 8'h65;
      4'd8:    v = 8'h63;
      4'd9:    v = 8'h68;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/lidar_frame_point_parser.sv =====
// Lidar frame point parser. Takes a recorded point-cloud file one byte per item on the
// input stream (tdata = byte, tuser = start-of-file flag, which restarts parsing at that
// byte). The 10-byte file magic is checked and the rest of the 88-byte file header
// skipped; frames follow, each with a 24-byte header whose bytes 8..15 give the
// little-endian absolute offset of the next frame. Packages are parsed while the byte
// position is below that offset; a type 2 package carries POINTS_PER_PACKAGE points of
// 14 bytes, and each point yields one item (tuser = 0) with signed x in tdata[31:0] and
// z in tdata[63:32], sent with the last z byte. When a frame header or a package body
// ends at or past the offset a frame-end item (tuser = 1, data zero) is sent. A bad magic
// sends tuser = 2 and the parser then drops bytes until the next start-of-file byte.
// Rate: one byte per clock sustained; the parser takes a byte each cycle while its
// two-entry result queue has room, so the input stalls only when the result stream is
// held off. A result is written into the queue and then into the output register.
module lidar_frame_point_parser #(
  parameter int POINTS_PER_PACKAGE = lfpp_pkg::PointsPerPackageDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] file_start
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [31:0] point_x, [63:32] point_z
  output logic [1:0]  m_axis_tuser_o    // [1:0] kind
);

  logic           q_full, q_not_empty, q_pop;
  logic           res_valid;
  lfpp_pkg::res_t res, q_data, out_data;

  // Front: byte-level layout walker
  lfpp_front #(
    .PointsPerPackage(POINTS_PER_PACKAGE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .data_byte_i (s_axis_tdata_i),
    .file_start_i(s_axis_tuser_i),
    .q_full_i    (q_full),
    .in_ready_o  (s_axis_tready_o),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Queue lets parser and output stall independently
  lfpp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .pop_i      (q_pop),
    .full_o     (q_full),
    .not_empty_o(q_not_empty),
    .pop_data_o (q_data)
  );

  // Back: registered output stage
  lfpp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_not_empty_i(q_not_empty),
    .q_data_i     (q_data),
    .q_pop_o      (q_pop),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_data_o   (out_data)
  );

  assign m_axis_tdata_o = {out_data.point_z, out_data.point_x};
  assign m_axis_tuser_o = out_data.kind;

endmodule

// ===== hdl/lfpp_front.sv =====
// Byte parser: walks the file layout, builds points and frame-end items.
module lfpp_front #(
  parameter int PointsPerPackage = lfpp_pkg::PointsPerPackageDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [7:0]     data_byte_i,
  input  logic           file_start_i,
  input  logic           q_full_i,
  output logic           in_ready_o,
  output logic           res_valid_o,
  output lfpp_pkg::res_t res_o
);

  localparam logic [2:0] PhMagic    = 3'd0;
  localparam logic [2:0] PhHdrSkip  = 3'd1;
  localparam logic [2:0] PhFrameHdr = 3'd2;
  localparam logic [2:0] PhPkgHdr   = 3'd3;
  localparam logic [2:0] PhPoints   = 3'd4;
  localparam logic [2:0] PhBodySkip = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic [6:0]  bif_q, bif_d;
  logic [63:0] pos_q, pos_d;
  logic [63:0] off_q, off_d;
  logic [7:0]  ptype_q, ptype_d;
  logic [6:0]  pidx_q, pidx_d;
  logic [31:0] x_q, x_d;
  logic [31:0] z_q, z_d;
  logic        magic_ok_q, magic_ok_d;
  logic        halted_q, halted_d;
  logic        accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    logic [6:0] k;
    logic       end_chk;
    phase_d     = phase_q;
    bif_d       = bif_q;
    pos_d       = pos_q;
    off_d       = off_q;
    ptype_d     = ptype_q;
    pidx_d      = pidx_q;
    x_d         = x_q;
    z_d         = z_q;
    magic_ok_d  = magic_ok_q;
    halted_d    = halted_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    k           = '0;
    end_chk     = 1'b0;
    if (accept) begin
      if (file_start_i) begin
        phase_d    = PhMagic;
        bif_d      = '0;
        pos_d      = '0;
        off_d      = '0;
        ptype_d    = '0;
        pidx_d     = '0;
        x_d        = '0;
        z_d        = '0;
        magic_ok_d = 1'b1;
        halted_d   = 1'b0;
      end
      if (!halted_d) begin
        pos_d = pos_d + 64'd1;
        k     = bif_d;
        bif_d = bif_d + 7'd1;
        case (phase_d)
          PhMagic: begin
            if (data_byte_i != lfpp_pkg::magic_byte(k[3:0])) magic_ok_d = 1'b0;
            if (bif_d >= lfpp_pkg::MagicLen) begin
              bif_d = '0;
              if (!magic_ok_d) begin
                halted_d    = 1'b1;
                res_valid_o = 1'b1;
                res_o.kind  = lfpp_pkg::KIND_BAD_MAGIC;
              end else begin
                phase_d = PhHdrSkip;
              end
            end
          end
          PhHdrSkip: begin
            if (bif_d >= lfpp_pkg::HdrSkipLen) begin
              bif_d   = '0;
              phase_d = PhFrameHdr;
            end
          end
          PhFrameHdr: begin
            // bytes 8..15: little-endian offset of the next frame
            if (k inside {[lfpp_pkg::OffsetFirst:lfpp_pkg::OffsetEnd - 7'd1]}) begin
              if (k == lfpp_pkg::OffsetFirst) off_d = '0;
              off_d[{k[2:0], 3'b000} +: 8] = data_byte_i;
            end
            if (bif_d >= lfpp_pkg::FrameHdrLen) end_chk = 1'b1;
          end
          PhPkgHdr: begin
            if (k == lfpp_pkg::TypeByte) ptype_d = data_byte_i;
            if (bif_d >= lfpp_pkg::PkgHdrLen) begin
              bif_d   = '0;
              pidx_d  = '0;
              phase_d = (ptype_d == lfpp_pkg::PointType) ? PhPoints : PhBodySkip;
            end
          end
          PhPoints: begin
            if (k < lfpp_pkg::XEnd) begin
              if (k == 7'd0) x_d = '0;
              x_d[{k[1:0], 3'b000} +: 8] = data_byte_i;
            end else if (k inside {[lfpp_pkg::ZFirst:lfpp_pkg::ZLast]}) begin
              if (k == lfpp_pkg::ZFirst) z_d = '0;
              z_d[{k[1:0], 3'b000} +: 8] = data_byte_i;
            end
            if (k == lfpp_pkg::ZLast) begin
              res_valid_o   = 1'b1;
              res_o.kind    = lfpp_pkg::KIND_POINT;
              res_o.point_x = x_d;
              res_o.point_z = z_d;
            end else if (bif_d >= lfpp_pkg::PointLen) begin
              bif_d  = '0;
              pidx_d = pidx_d + 7'd1;
              if (pidx_d >= 7'(PointsPerPackage)) end_chk = 1'b1;
            end
          end
          PhBodySkip: begin
            if (bif_d >= lfpp_pkg::BodySkipLen) end_chk = 1'b1;
          end
          default: halted_d = 1'b1;
        endcase
        if (end_chk) begin
          bif_d = '0;
          if (pos_d >= off_d) begin
            phase_d     = PhFrameHdr;
            res_valid_o = 1'b1;
            res_o.kind  = lfpp_pkg::KIND_FRAME_END;
          end else begin
            phase_d = PhPkgHdr;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhMagic;
      bif_q      <= '0;
      pos_q      <= '0;
      off_q      <= '0;
      ptype_q    <= '0;
      pidx_q     <= '0;
      x_q        <= '0;
      z_q        <= '0;
      magic_ok_q <= 1'b1;
      halted_q   <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      bif_q      <= bif_d;
      pos_q      <= pos_d;
      off_q      <= off_d;
      ptype_q    <= ptype_d;
      pidx_q     <= pidx_d;
      x_q        <= x_d;
      z_q        <= z_d;
      magic_ok_q <= magic_ok_d;
      halted_q   <= halted_d;
    end
  end

  a_bad_magic_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == lfpp_pkg::KIND_BAD_MAGIC |=> halted_q)
    else $error("bad magic item without halt");

  a_point_in_points: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == lfpp_pkg::KIND_POINT |-> phase_q == PhPoints)
    else $error("point item outside point phase");

  a_halted_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q && !file_start_i |-> !res_valid_o)
    else $error("item while halted");

endmodule

// ===== hdl/lfpp_queue.sv =====
// Short result queue between parser and output stage.
module lfpp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lfpp_pkg::res_t push_data_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           not_empty_o,
  output lfpp_pkg::res_t pop_data_o
);

  localparam int PtrW = $clog2(lfpp_pkg::QueueDepth);
  localparam int CntW = $clog2(lfpp_pkg::QueueDepth + 1);

  lfpp_pkg::res_t mem_q [lfpp_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o      = cnt_q == CntW'(lfpp_pkg::QueueDepth);
  assign not_empty_o = cnt_q != '0;
  assign pop_data_o  = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(lfpp_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(lfpp_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(lfpp_pkg::QueueDepth))
    else $error("queue count overflow");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

endmodule

// ===== hdl/lfpp_back.sv =====
// Output register stage: drains the queue onto the result stream.
module lfpp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_not_empty_i,
  input  lfpp_pkg::res_t q_data_i,
  output logic           q_pop_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output lfpp_pkg::res_t out_data_o
);

  logic           valid_q;
  lfpp_pkg::res_t data_q;

  assign q_pop_o     = q_not_empty_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= q_not_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) data_q <= q_data_i;
  end

endmodule
